>>> rtl/core/gca_pkg.sv
`default_nettype none
package gca_pkg;

	localparam int VALUE_W = 32;
	localparam int TOL_W = 31;
	localparam int ID_W = 16;
	localparam int COUNT_W = 17;
	localparam int SUM_W = 49;
	// magnitude of a sum over at most 65536 values
	localparam int MAG_W = SUM_W - 1;
	localparam int STEP_W = 5;

	localparam logic [ID_W-1:0] ID_LIMIT = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 17'h10000;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_AVERAGE = 1'b1;

	typedef struct packed {
		logic start;
		logic signed [SUM_W-1:0] dividend;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic busy;
		logic signed [VALUE_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/gca_divider.sv
`default_nettype none
module gca_divider (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gca_pkg::div_req_t   req,
	output gca_pkg::div_rsp_t   rsp
);

	// restoring divide, one quotient bit a cycle; the mean fits in 32 bits,
	// so the top 16 magnitude bits seed the remainder directly
	logic busy_q;
	logic done_q;
	logic [gca_pkg::STEP_W-1:0] step_q;
	logic neg_q;
	logic [gca_pkg::COUNT_W:0] rem_q;
	logic [gca_pkg::VALUE_W-1:0] dq_q;
	logic [gca_pkg::COUNT_W-1:0] div_q;
	logic signed [gca_pkg::VALUE_W-1:0] res_q;

	logic [gca_pkg::MAG_W-1:0] mag;
	logic [gca_pkg::COUNT_W:0] shifted;
	logic ge;
	logic [gca_pkg::VALUE_W-1:0] dq_next;

	assign mag = req.dividend[gca_pkg::SUM_W-1]
		? gca_pkg::MAG_W'(-req.dividend) : req.dividend[gca_pkg::MAG_W-1:0];
	assign shifted = {rem_q[gca_pkg::COUNT_W-1:0], dq_q[gca_pkg::VALUE_W-1]};
	assign ge = (shifted >= {1'b0, div_q});
	assign dq_next = {dq_q[gca_pkg::VALUE_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.divisor <= gca_pkg::COUNT_W'(1)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= '0;
				end
			end else if (busy_q) begin
				step_q <= step_q + gca_pkg::STEP_W'(1);
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[gca_pkg::SUM_W-1];
			rem_q <= {2'b00, mag[gca_pkg::MAG_W-1:gca_pkg::VALUE_W]};
			dq_q <= mag[gca_pkg::VALUE_W-1:0];
			div_q <= req.divisor;
			if (req.divisor <= gca_pkg::COUNT_W'(1)) begin
				res_q <= req.dividend[gca_pkg::VALUE_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, div_q}) : shifted;
			dq_q <= dq_next;
			if (step_q == '1) begin
				res_q <= neg_q ? -$signed(dq_next) : $signed(dq_next);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quotient = res_q;

endmodule
`default_nettype wire

>>> rtl/core/gap_cluster_averager.sv
`default_nettype none
// one-dimensional gap clustering of values that arrive already in ascending
// order, signed q16.16, one per input beat, the final value of a data set
// flagged by last_item. every input beat yields an assignment result (kind 0)
// with its cluster id; a gap larger than tolerance first yields the average
// of the cluster it closes (kind 1), and last_item adds the final average
// (kind 1) carrying the cluster count, after which the block clears for the
// next data set. last_of_run marks the last result of each input beat. the
// mean is sum / count truncated toward zero, worked out by one shared
// restoring divider at one quotient bit per cycle; a single-member cluster
// skips the divide. an input beat with no average passes through the
// assignment emit state; each average it causes adds a wait on the divider
// and its own emit state, and output stalls hold the sequencer. the next
// input is taken while the last result still waits in the output register.
// tolerance is written through the cfg channel, which is always ready; the
// user must write it only while the block is idle; nothing here enforces it.
module gap_cluster_averager (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [gca_pkg::TOL_W-1:0]            tolerance,
	// input beats
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  signed [gca_pkg::VALUE_W-1:0]   value,
	input  wire                                  last_item,
	// result beats
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 kind,
	output logic [gca_pkg::ID_W-1:0]             cluster_id,
	output logic signed [gca_pkg::VALUE_W-1:0]   average,
	output logic [gca_pkg::COUNT_W-1:0]          cluster_count,
	output logic                                 last_of_run
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE        = 3'd0;
	localparam logic [2:0] ST_DIV_CLOSE   = 3'd1;
	localparam logic [2:0] ST_EMIT_CLOSE  = 3'd2;
	localparam logic [2:0] ST_EMIT_ASSIGN = 3'd3;
	localparam logic [2:0] ST_DIV_FINAL   = 3'd4;
	localparam logic [2:0] ST_EMIT_FINAL  = 3'd5;

	logic [2:0] state_q;
	logic [gca_pkg::TOL_W-1:0] tol_q;

	// cluster state
	logic started_q;
	logic signed [gca_pkg::VALUE_W-1:0] prev_q;
	logic [gca_pkg::ID_W-1:0] cluster_q;
	logic [gca_pkg::COUNT_W-1:0] count_q;
	logic signed [gca_pkg::SUM_W-1:0] sum_q;
	logic last_q;
	logic [gca_pkg::ID_W-1:0] close_id_q;

	// output register
	logic out_valid_q;
	logic kind_q;
	logic [gca_pkg::ID_W-1:0] id_q;
	logic signed [gca_pkg::VALUE_W-1:0] avg_q;
	logic [gca_pkg::COUNT_W-1:0] ccount_q;
	logic lor_q;

	gca_pkg::div_req_t div_req;
	gca_pkg::div_rsp_t div_rsp;

	logic accept;
	logic slot_free;
	logic signed [gca_pkg::VALUE_W:0] gap;
	logic gap_open;
	logic signed [gca_pkg::SUM_W-1:0] sum_add;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	// the output register can take a new result this cycle
	assign slot_free = !out_valid_q || out_ready;

	// gap test against the previous value, 33 bits so it never wraps
	assign gap = {value[gca_pkg::VALUE_W-1], value} - {prev_q[gca_pkg::VALUE_W-1], prev_q};
	assign gap_open = started_q && (gap > $signed({2'b00, tol_q}));
	assign sum_add = sum_q + gca_pkg::SUM_W'(value);

	// divider is started on the cluster held in the state registers: the old
	// one on a closing gap, the current one after the assignment of a last item
	assign div_req.start = (accept && gap_open)
		|| (state_q == ST_EMIT_ASSIGN && slot_free && last_q);
	assign div_req.dividend = sum_q;
	assign div_req.divisor = count_q;

	gca_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid) begin
			tol_q <= tolerance;
		end
	end

	// sequencer and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			prev_q <= '0;
			cluster_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_item;
						prev_q <= value;
						started_q <= 1'b1;
						if (!started_q) begin
							cluster_q <= '0;
							count_q <= gca_pkg::COUNT_W'(1);
							sum_q <= gca_pkg::SUM_W'(value);
							state_q <= ST_EMIT_ASSIGN;
						end else if (gap_open) begin
							// close the cluster; id sticks at its limit
							if (cluster_q != gca_pkg::ID_LIMIT) begin
								cluster_q <= cluster_q + gca_pkg::ID_W'(1);
							end
							count_q <= gca_pkg::COUNT_W'(1);
							sum_q <= gca_pkg::SUM_W'(value);
							state_q <= ST_DIV_CLOSE;
						end else begin
							// a full cluster still takes members, not into the sum
							if (count_q != gca_pkg::COUNT_LIMIT) begin
								count_q <= count_q + gca_pkg::COUNT_W'(1);
								sum_q <= sum_add;
							end
							state_q <= ST_EMIT_ASSIGN;
						end
					end
				end
				ST_DIV_CLOSE: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT_CLOSE;
					end
				end
				ST_EMIT_CLOSE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_EMIT_ASSIGN;
					end
				end
				ST_EMIT_ASSIGN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= last_q ? ST_DIV_FINAL : ST_IDLE;
					end
				end
				ST_DIV_FINAL: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT_FINAL;
					end
				end
				ST_EMIT_FINAL: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						// data set done, start over
						started_q <= 1'b0;
						prev_q <= '0;
						cluster_q <= '0;
						count_q <= '0;
						sum_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			close_id_q <= cluster_q;
		end
		if (slot_free) begin
			if (state_q == ST_EMIT_CLOSE) begin
				kind_q <= gca_pkg::KIND_AVERAGE;
				id_q <= close_id_q;
				avg_q <= div_rsp.quotient;
				ccount_q <= '0;
				lor_q <= 1'b0;
			end else if (state_q == ST_EMIT_ASSIGN) begin
				kind_q <= gca_pkg::KIND_ASSIGN;
				id_q <= cluster_q;
				avg_q <= '0;
				ccount_q <= '0;
				lor_q <= !last_q;
			end else if (state_q == ST_EMIT_FINAL) begin
				kind_q <= gca_pkg::KIND_AVERAGE;
				id_q <= cluster_q;
				avg_q <= div_rsp.quotient;
				ccount_q <= {1'b0, cluster_q} + gca_pkg::COUNT_W'(1);
				lor_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign cluster_id = id_q;
	assign average = avg_q;
	assign cluster_count = ccount_q;
	assign last_of_run = lor_q;

	// a final average always ends the run of its input beat
	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == gca_pkg::KIND_AVERAGE && cluster_count != '0 |-> last_of_run)
		else $error("final average without last_of_run");

	// assignment beats carry no average and no count
	a_assign_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == gca_pkg::KIND_ASSIGN |-> average == '0 && cluster_count == '0)
		else $error("assignment beat with stray payload");

	// the divider only finishes while the sequencer waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_CLOSE || state_q == ST_DIV_FINAL))
		else $error("divider done outside a wait state");

	// an accepted input always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted without starting work");

endmodule
`default_nettype wire

>>> tb/cluster_result_checker.sv
`default_nettype none
module cluster_result_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	input  wire                                  cfg_ready,
	input  wire  [gca_pkg::TOL_W-1:0]            tolerance,
	input  wire                                  in_valid,
	input  wire                                  in_ready,
	input  wire  signed [gca_pkg::VALUE_W-1:0]   value,
	input  wire                                  last_item,
	input  wire                                  out_valid,
	input  wire                                  out_ready,
	input  wire                                  kind,
	input  wire  [gca_pkg::ID_W-1:0]             cluster_id,
	input  wire  signed [gca_pkg::VALUE_W-1:0]   average,
	input  wire  [gca_pkg::COUNT_W-1:0]          cluster_count,
	input  wire                                  last_of_run,
	output int                                   mismatches,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct packed {
		logic                               kind;
		logic [gca_pkg::ID_W-1:0]           id;
		logic signed [gca_pkg::VALUE_W-1:0] avg;
		logic [gca_pkg::COUNT_W-1:0]        count;
		logic                               last;
	} cluster_result_t;

	// cluster state mirrored from the block
	logic [gca_pkg::TOL_W-1:0]          tol_q;
	logic signed [gca_pkg::VALUE_W-1:0] prev_value;
	logic [gca_pkg::ID_W-1:0]           cur_id;
	logic [gca_pkg::COUNT_W-1:0]        members;
	longint                             member_sum;
	logic                               set_open;
	int                                 errors;

	cluster_result_t awaited_results[$];

	function automatic logic signed [gca_pkg::VALUE_W-1:0] mean_of(input longint s,
			input logic [gca_pkg::COUNT_W-1:0] n);
		longint m;
		m = (n > 1) ? s / longint'(n) : s;
		if (m > VMAX) m = VMAX;
		if (m < VMIN) m = VMIN;
		return m[gca_pkg::VALUE_W-1:0];
	endfunction

	function automatic cluster_result_t make_result(input logic k,
			input logic [gca_pkg::ID_W-1:0] id,
			input logic signed [gca_pkg::VALUE_W-1:0] avg,
			input logic [gca_pkg::COUNT_W-1:0] count);
		cluster_result_t r;
		r.kind = k;
		r.id = id;
		r.avg = avg;
		r.count = count;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void cluster_next(input logic signed [gca_pkg::VALUE_W-1:0] v,
			input logic final_item);
		cluster_result_t batch[$];
		longint gap;
		if (!set_open) begin
			set_open = 1'b1;
			cur_id = '0;
			members = gca_pkg::COUNT_W'(1);
			member_sum = longint'(v);
		end else begin
			gap = longint'(v) - longint'(prev_value);
			if (gap > longint'({1'b0, tol_q})) begin
				batch.push_back(make_result(gca_pkg::KIND_AVERAGE, cur_id,
					mean_of(member_sum, members), '0));
				if (cur_id != gca_pkg::ID_LIMIT) cur_id = cur_id + 1'b1;
				members = gca_pkg::COUNT_W'(1);
				member_sum = longint'(v);
			end else if (members < gca_pkg::COUNT_LIMIT) begin
				members = members + 1'b1;
				member_sum = member_sum + longint'(v);
			end
		end
		prev_value = v;
		batch.push_back(make_result(gca_pkg::KIND_ASSIGN, cur_id, '0, '0));
		if (final_item) begin
			batch.push_back(make_result(gca_pkg::KIND_AVERAGE, cur_id,
				mean_of(member_sum, members), {1'b0, cur_id} + 1'b1));
			set_open = 1'b0;
			cur_id = '0;
			members = '0;
			member_sum = 0;
			prev_value = '0;
		end
		batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) awaited_results.push_back(batch[i]);
	endfunction

	function automatic void check_beat();
		cluster_result_t want, got;
		got = make_result(kind, cluster_id, average, cluster_count);
		got.last = last_of_run;
		if (awaited_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: kind %0d id %0d avg %0d count %0d last %0d",
					got.kind, got.id, got.avg, got.count, got.last);
		end else begin
			want = awaited_results.pop_front();
			if (got.kind !== want.kind || got.id !== want.id || got.avg !== want.avg ||
					got.count !== want.count || got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch: want kind %0d id %0d avg %0d count %0d last %0d",
						want.kind, want.id, want.avg, want.count, want.last);
					$display("                 got  kind %0d id %0d avg %0d count %0d last %0d",
						got.kind, got.id, got.avg, got.count, got.last);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q = '0;
			prev_value = '0;
			cur_id = '0;
			members = '0;
			member_sum = 0;
			set_open = 1'b0;
			errors = 0;
			awaited_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) tol_q = tolerance;
			if (out_valid && out_ready) check_beat();
			if (in_valid && in_ready) cluster_next(value, last_item);
			mismatches <= errors;
			pending <= awaited_results.size();
		end
	end

endmodule
`default_nettype wire

>>> tb/gap_cluster_averager_test.sv
`default_nettype none
module gap_cluster_averager_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	// cycles without any handshake before giving up
	localparam int STALL_LIMIT = 2000;
	// cycles to watch for stray results once everything has arrived
	localparam int TAIL_CYCLES = 100;
	localparam int PHASE_ITEMS = 45;

	logic clk;
	logic arst_n = 1'b0;

	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic [gca_pkg::TOL_W-1:0]          tolerance = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [gca_pkg::VALUE_W-1:0] value = '0;
	logic                               last_item = 1'b0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               kind;
	logic [gca_pkg::ID_W-1:0]           cluster_id;
	logic signed [gca_pkg::VALUE_W-1:0] average;
	logic [gca_pkg::COUNT_W-1:0]        cluster_count;
	logic                               last_of_run;

	int mismatches;
	int pending;
	int stall_cycles = 0;
	int sent = 0;
	// no idling on either side while set
	logic quiet = 1'b0;

	gap_cluster_averager u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.tolerance     (tolerance),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.cluster_id    (cluster_id),
		.average       (average),
		.cluster_count (cluster_count),
		.last_of_run   (last_of_run)
	);

	cluster_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.tolerance     (tolerance),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.cluster_id    (cluster_id),
		.average       (average),
		.cluster_count (cluster_count),
		.last_of_run   (last_of_run),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: stall about one beat in ten unless quiet
	always @(posedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
	end

	// watchdog: count cycles in which no channel moves a beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// one input beat; valid stays up across back-to-back beats
	task automatic send_value(input logic signed [gca_pkg::VALUE_W-1:0] v,
			input logic final_item);
		if (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last_item <= final_item;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		// pending is registered, so let it update before looking at it
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [gca_pkg::TOL_W-1:0] t);
		cfg_valid <= 1'b1;
		tolerance <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// one data set in mostly ascending order; steps straddle the tolerance
	task automatic random_set(input logic [gca_pkg::TOL_W-1:0] tol, input int len);
		longint cur;
		longint step;
		longint t;
		int pick;
		t = longint'(tol);
		cur = longint'(int'($urandom));
		// leave headroom above the start most of the time
		if ($urandom_range(3) != 0) cur = cur >>> 2;
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					step = longint'($urandom_range(255));
					if (step > t) step = t;
				end else if (pick < 50)
					step = t;                     // gap exactly at tolerance, joins
				else if (pick < 62)
					step = t + 1;                 // smallest gap that closes
				else if (pick < 82)
					step = t + 1 + longint'($urandom_range(1 << 20));
				else if (pick < 92)
					step = longint'($urandom) % (t + 1);
				else if (pick < 96)
					step = -longint'($urandom_range(1, 1000));   // out of order
				else
					step = longint'(int'($urandom)) - cur;       // arbitrary value
				cur = cur + step;
				if (cur > VMAX) cur = VMAX;
				if (cur < VMIN) cur = VMIN;
			end
			send_value(cur[gca_pkg::VALUE_W-1:0], i == len - 1);
		end
	endtask

	initial begin
		logic [gca_pkg::TOL_W-1:0] tol;
		int phase_start;
		int len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets at the reset tolerance of zero
		// single-member sets at both ends of the range
		send_value(VMIN[gca_pkg::VALUE_W-1:0], 1'b1);
		send_value(VMAX[gca_pkg::VALUE_W-1:0], 1'b1);
		// widest possible gap closes a single-member cluster
		send_value(VMIN[gca_pkg::VALUE_W-1:0], 1'b0);
		send_value(VMAX[gca_pkg::VALUE_W-1:0], 1'b1);
		// equal values join, the next step closes a three-member cluster
		send_value(32'sd5, 1'b0);
		send_value(32'sd5, 1'b0);
		send_value(32'sd5, 1'b0);
		send_value(32'sd6, 1'b1);
		// falling values are never a gap
		send_value(32'sd100, 1'b0);
		send_value(32'sd50, 1'b0);
		send_value(32'sd40, 1'b1);
		drain_results();

		write_tolerance(31'd3);
		// negative mean truncates toward zero
		send_value(-32'sd3, 1'b0);
		send_value(-32'sd2, 1'b0);
		send_value(-32'sd2, 1'b0);
		send_value(32'sd7, 1'b0);
		send_value(32'sd8, 1'b1);
		// gap equal to tolerance joins, one more closes
		send_value(32'sd0, 1'b0);
		send_value(32'sd3, 1'b0);
		send_value(32'sd7, 1'b1);
		drain_results();

		// random sets under several tolerances, extremes included
		for (int p = 0; p < 6; p++) begin
			unique case (p)
				0: tol = '0;
				1: tol = 31'd1;
				2: tol = 31'h10000;
				3: tol = '1;
				4: tol = gca_pkg::TOL_W'($urandom);
				default: tol = gca_pkg::TOL_W'($urandom_range(32'h3FFFF));
			endcase
			drain_results();
			write_tolerance(tol);
			// one phase runs with both sides at full rate
			quiet <= (p == 2);
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
				random_set(tol, len);
				// now and then let the block run dry between sets
				if ($urandom_range(5) == 0) drain_results();
			end
		end
		drain_results();
		quiet <= 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
rtl/core/gca_pkg.sv
rtl/core/gca_divider.sv
rtl/core/gap_cluster_averager.sv
tb/cluster_result_checker.sv
tb/gap_cluster_averager_test.sv
